@@ rtl/bft_pkg.sv @@
`timescale 1ns / 1ps
// bft_pkg: shared types and constants of the byte frequency top list block
// no dependencies

package bft_pkg;

  localparam int TopEntriesDef = 10;
  localparam int CountBitsDef  = 32;
  localparam int TableDepth    = 256;
  localparam int SymW          = 8;
  localparam int RankW         = 4;
  localparam int OccW          = 32;
  localparam int DistW         = 9;

  typedef enum logic {
    KIND_COUNT  = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_PLACE  = 5'b00100,
    ST_BUBBLE = 5'b01000,
    ST_REPORT = 5'b10000
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [SymW-1:0]   byte_value;
  } in_word_t;

  typedef struct packed {
    logic [RankW-1:0]  rank;
    logic [SymW-1:0]   symbol;
    logic [OccW-1:0]   occurrences;
    logic [DistW-1:0]  distinct_total;
    logic              list_empty;
    logic              last;
  } out_word_t;

endpackage

@@ rtl/bft_chan_if.sv @@
`timescale 1ns / 1ps
// bft_chan_if: valid/ready channel carrying one word of a given type
// word types come from bft_pkg

interface bft_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bft_count_mem.sv @@
`timescale 1ns / 1ps
// bft_count_mem: 256-entry count table with registered read and per-entry valid bits
// uses bft_pkg

module bft_count_mem
  import bft_pkg::*;
#(
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [SymW-1:0]       rd_addr_i,
  output logic [COUNT_BITS-1:0] rd_data_o,
  input  logic                  wr_en_i,
  input  logic [SymW-1:0]       wr_addr_i,
  input  logic [COUNT_BITS-1:0] wr_data_i
);

  logic [COUNT_BITS-1:0] mem_q [TableDepth];
  logic [TableDepth-1:0] vld_q;
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

@@ rtl/bft_rank_cmp.sv @@
`timescale 1ns / 1ps
// bft_rank_cmp: shared rank comparator, higher count wins, smaller byte on a tie
// uses bft_pkg

module bft_rank_cmp
  import bft_pkg::*;
#(
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic [COUNT_BITS-1:0] a_cnt_i,
  input  logic [SymW-1:0]       a_sym_i,
  input  logic [COUNT_BITS-1:0] b_cnt_i,
  input  logic [SymW-1:0]       b_sym_i,
  output logic                  a_wins_o
);

  assign a_wins_o = (a_cnt_i > b_cnt_i) || ((a_cnt_i == b_cnt_i) && (a_sym_i < b_sym_i));

endmodule

@@ rtl/byte_frequency_top_ten_unit.sv @@
`timescale 1ns / 1ps
// byte_frequency_top_ten_unit: byte counter with a ranked list of the most frequent bytes
// uses bft_pkg, bft_chan_if, bft_count_mem, bft_rank_cmp
//
//   channel  dir  handshake      word
//   in_i     in   valid/ready    kind, byte_value
//   out_o    out  valid/ready    rank, symbol, occurrences, distinct_total, list_empty, last
//
// a count word goes through table read, table write and list search, an optional compare
// against the weakest entry, then one bubble step per cycle through the single rank
// comparator until the entry settles
// a report word gives one result word per cycle while out_o is ready
// in_i is ready only between words; the count table needs no clearing after reset

module byte_frequency_top_ten_unit
  import bft_pkg::*;
#(
  parameter int TOP_ENTRIES = TopEntriesDef,
  parameter int COUNT_BITS  = CountBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bft_chan_if.sink          in_i,
  bft_chan_if.source        out_o
);

  localparam int IDX_W  = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;
  localparam int FILL_W = $clog2(TOP_ENTRIES + 1);
  localparam logic [IDX_W-1:0]  LastIdx  = IDX_W'(TOP_ENTRIES - 1);
  localparam logic [FILL_W-1:0] FullFill = FILL_W'(TOP_ENTRIES);

  state_e                state_q, state_d;
  logic [SymW-1:0]       byte_q;
  logic [IDX_W-1:0]      pos_q, pos_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [DistW-1:0]      dist_q, dist_d;
  logic [SymW-1:0]       mov_sym_q, mov_sym_d;
  logic [COUNT_BITS-1:0] mov_cnt_q, mov_cnt_d;

  logic [SymW-1:0]       lst_sym_q [TOP_ENTRIES];
  logic [COUNT_BITS-1:0] lst_cnt_q [TOP_ENTRIES];

  logic                  in_acc;
  logic                  mem_rd_en;
  logic                  mem_wr_en;
  logic [COUNT_BITS-1:0] mem_rd_data;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic [SymW-1:0]       rd_sym;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  wins;
  logic                  lst_we;
  logic [IDX_W-1:0]      lst_wa;
  logic [SymW-1:0]       lst_wsym;
  logic [COUNT_BITS-1:0] lst_wcnt;
  logic                  rep_empty;
  logic                  rep_last;
  logic [63:0]           occ_wide;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign mem_rd_en  = in_acc && (in_i.data.kind == KIND_COUNT);
  assign mem_wr_en  = (state_q == ST_READ);

  bft_count_mem #(
    .COUNT_BITS (COUNT_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (in_i.data.byte_value),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (byte_q),
    .wr_data_i (cnt_new)
  );

  // saturating increment
  assign cnt_new = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + COUNT_BITS'(1);

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < TOP_ENTRIES; i++) begin
      if ((FILL_W'(i) < fill_q) && (lst_sym_q[i] == byte_q)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  // single list read port shared by placement, bubbling and report
  always_comb begin
    case (state_q)
      ST_REPORT: rd_idx = idx_q;
      ST_PLACE:  rd_idx = LastIdx;
      default:   rd_idx = pos_q - IDX_W'(1);
    endcase
  end

  assign rd_sym = lst_sym_q[rd_idx];
  assign rd_cnt = lst_cnt_q[rd_idx];

  bft_rank_cmp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cmp (
    .a_cnt_i  (mov_cnt_q),
    .a_sym_i  (mov_sym_q),
    .b_cnt_i  (rd_cnt),
    .b_sym_i  (rd_sym),
    .a_wins_o (wins)
  );

  assign rep_empty = (fill_q == '0);
  assign rep_last  = rep_empty || (FILL_W'(idx_q) == fill_q - FILL_W'(1));
  assign occ_wide  = 64'(rd_cnt);

  always_comb begin
    out_o.valid               = (state_q == ST_REPORT);
    out_o.data.rank           = rep_empty ? '0 : RankW'(idx_q);
    out_o.data.symbol         = rep_empty ? '0 : rd_sym;
    out_o.data.occurrences    = rep_empty ? '0 : occ_wide[OccW-1:0];
    out_o.data.distinct_total = rep_empty ? '0 : dist_q;
    out_o.data.list_empty     = rep_empty;
    out_o.data.last           = rep_last;
  end

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    idx_d     = idx_q;
    fill_d    = fill_q;
    dist_d    = dist_q;
    mov_sym_d = mov_sym_q;
    mov_cnt_d = mov_cnt_q;
    lst_we    = 1'b0;
    lst_wa    = pos_q;
    lst_wsym  = mov_sym_q;
    lst_wcnt  = mov_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d = '0;
          if (in_i.data.kind == KIND_COUNT) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_REPORT;
          end
        end
      end
      ST_READ: begin
        mov_sym_d = byte_q;
        mov_cnt_d = cnt_new;
        if (mem_rd_data == '0) begin
          dist_d = dist_q + DistW'(1);
        end
        if (hit) begin
          pos_d   = hit_idx;
          state_d = ST_BUBBLE;
        end else if (fill_q < FullFill) begin
          pos_d   = IDX_W'(fill_q);
          fill_d  = fill_q + FILL_W'(1);
          state_d = ST_BUBBLE;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (wins) begin
          pos_d   = LastIdx;
          state_d = ST_BUBBLE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_BUBBLE: begin
        lst_we = 1'b1;
        if ((pos_q != '0) && wins) begin
          lst_wsym = rd_sym;
          lst_wcnt = rd_cnt;
          pos_d    = pos_q - IDX_W'(1);
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (out_o.ready) begin
          if (rep_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      idx_q   <= '0;
      fill_q  <= '0;
      dist_q  <= '0;
      for (int i = 0; i < TOP_ENTRIES; i++) begin
        lst_sym_q[i] <= '0;
        lst_cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      idx_q   <= idx_d;
      fill_q  <= fill_d;
      dist_q  <= dist_d;
      if (lst_we) begin
        lst_sym_q[lst_wa] <= lst_wsym;
        lst_cnt_q[lst_wa] <= lst_wcnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_rd_en) begin
      byte_q <= in_i.data.byte_value;
    end
    mov_sym_q <= mov_sym_d;
    mov_cnt_q <= mov_cnt_d;
  end

endmodule

@@ test/byte_frequency_top_ten_unit_tb.sv @@
`timescale 1ns / 1ps
// byte_frequency_top_ten_unit_tb: self-checking bench for the byte counter with ranked top list
// needs bft_pkg, bft_chan_if and byte_frequency_top_ten_unit; predicts every report word and
// checks it field by field under random gaps on both channels and one long output stall

module byte_frequency_top_ten_unit_tb;
  import bft_pkg::*;

  localparam int     TopN       = TopEntriesDef;
  localparam int     StallLimit = 2000;
  localparam int     HoldCycles = 300;
  localparam int     SettleCyc  = TopEntriesDef + 20;
  localparam longint CountMax   = (64'd1 << CountBitsDef) - 64'd1;

  typedef struct {
    logic [SymW-1:0] sym;
    longint          cnt;
  } slot_t;

  logic clk_i;
  logic rst_ni;

  bft_chan_if #(.payload_t(in_word_t))  in_if ();
  bft_chan_if #(.payload_t(out_word_t)) out_if ();

  byte_frequency_top_ten_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state
  longint          tally [TableDepth];
  slot_t           board [TopN];
  int              board_fill;
  int              distinct_seen;
  out_word_t       pending_ranks [$];

  int              fails;
  bit              no_gaps;
  int              hold_len;
  logic [SymW-1:0] hot_bytes [8];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit beats(longint ca, logic [SymW-1:0] sa, longint cb,
                               logic [SymW-1:0] sb);
    return (ca > cb) || (ca == cb && sa < sb);
  endfunction

  function automatic void bubble_slot(int pos);
    slot_t t;
    while (pos > 0 && beats(board[pos].cnt, board[pos].sym,
                            board[pos-1].cnt, board[pos-1].sym)) begin
      t            = board[pos];
      board[pos]   = board[pos-1];
      board[pos-1] = t;
      pos--;
    end
  endfunction

  function automatic void tally_byte(logic [SymW-1:0] b);
    longint c;
    c = tally[b];
    if (c == 0) distinct_seen++;
    if (c < CountMax) c++;
    tally[b] = c;
    for (int i = 0; i < board_fill; i++) begin
      if (board[i].sym == b) begin
        board[i].cnt = c;
        bubble_slot(i);
        return;
      end
    end
    if (board_fill < TopN) begin
      board[board_fill].sym = b;
      board[board_fill].cnt = c;
      bubble_slot(board_fill);
      board_fill++;
    end else if (beats(c, b, board[TopN-1].cnt, board[TopN-1].sym)) begin
      board[TopN-1].sym = b;
      board[TopN-1].cnt = c;
      bubble_slot(TopN - 1);
    end
  endfunction

  function automatic void queue_ranking();
    out_word_t w;
    if (board_fill == 0) begin
      w            = '0;
      w.list_empty = 1'b1;
      w.last       = 1'b1;
      pending_ranks = {pending_ranks, w};
      return;
    end
    for (int i = 0; i < board_fill; i++) begin
      w.rank           = RankW'(i);
      w.symbol         = board[i].sym;
      w.occurrences    = board[i].cnt[OccW-1:0];
      w.distinct_total = DistW'(distinct_seen);
      w.list_empty     = 1'b0;
      w.last           = (i + 1 == board_fill);
      pending_ranks = {pending_ranks, w};
    end
  endfunction

  // valid stays high after acceptance so that back-to-back words need no second assignment
  task automatic send_word(kind_e k, logic [SymW-1:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{kind: k, byte_value: b};
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    if (k == KIND_COUNT) tally_byte(b);
    else queue_ranking();
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic test_empty_report();
    send_word(KIND_REPORT, 8'hFF);
    wait_idle();
  endtask

  task automatic test_extremes_and_ties();
    send_word(KIND_COUNT, 8'hFF);
    send_word(KIND_COUNT, 8'h00);
    send_word(KIND_REPORT, 8'h00);
    send_word(KIND_COUNT, 8'hFF);
    send_word(KIND_REPORT, 8'hA5);
    wait_idle();
  endtask

  task automatic test_full_list();
    for (int i = 7; i >= 0; i--) send_word(KIND_COUNT, 8'(1 << i));
    // weakest is 0x80 at one: eight entries leave room, so a smaller and a larger newcomer both join
    send_word(KIND_COUNT, 8'h7F);
    send_word(KIND_COUNT, 8'hFE);
    send_word(KIND_REPORT, 8'h00);
    send_word(KIND_COUNT, 8'hFE);
    send_word(KIND_REPORT, 8'h00);
    wait_idle();
  endtask

  task automatic test_output_stall();
    hold_len = HoldCycles;
    send_word(KIND_REPORT, 8'h3C);
    for (int i = 0; i < 12; i++) send_word(KIND_COUNT, hot_bytes[$urandom_range(0, 7)]);
    send_word(KIND_REPORT, 8'hC3);
    wait_idle();
  endtask

  task automatic test_random_traffic(int n, bit fast);
    int pick;
    no_gaps = fast;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) send_word(KIND_REPORT, 8'($urandom_range(0, 255)));
      else if (pick < 60) send_word(KIND_COUNT, hot_bytes[$urandom_range(0, 7)]);
      else send_word(KIND_COUNT, 8'($urandom_range(0, 255)));
    end
    send_word(KIND_REPORT, 8'($urandom_range(0, 255)));
    wait_idle();
    no_gaps = 1'b0;
  endtask

  // output side
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_len > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready) && hold_len == 0);
    end
  end

  function automatic int field_diff(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin : check_words
    out_word_t want;
    out_word_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_ranks.size() == 0) begin
        $error("result word with nothing pending: symbol %0d", got.symbol);
        fails++;
      end else begin
        want = pending_ranks.pop_front();
        fails += field_diff("rank", want.rank, got.rank);
        fails += field_diff("symbol", want.symbol, got.symbol);
        fails += field_diff("occurrences", want.occurrences, got.occurrences);
        fails += field_diff("distinct_total", want.distinct_total, got.distinct_total);
        fails += field_diff("list_empty", want.list_empty, got.list_empty);
        fails += field_diff("last", want.last, got.last);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) break;
    end
    $display("byte_frequency_top_ten_unit_tb: FAIL");
    $finish;
  end

  initial begin
    fails         = 0;
    no_gaps       = 1'b0;
    hold_len      = 0;
    board_fill    = 0;
    distinct_seen = 0;
    foreach (tally[i]) tally[i] = 0;
    foreach (board[i]) board[i] = '{sym: '0, cnt: 0};
    foreach (hot_bytes[i]) hot_bytes[i] = 8'($urandom_range(0, 255));
    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '{kind: KIND_COUNT, byte_value: 8'h00};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_report();
    test_extremes_and_ties();
    test_full_list();
    test_random_traffic(60, 1'b0);
    test_output_stall();
    test_random_traffic(60, 1'b1);
    test_random_traffic(60, 1'b0);
    test_random_traffic(50, 1'b0);

    if (fails == 0) begin
      $display("byte_frequency_top_ten_unit_tb: PASS");
    end else begin
      $display("byte_frequency_top_ten_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
